// ===== hw/rtl/hrrn_scheduler_top_assert.svh =====
// ----------------------------------------------------------------------------
// HRRN scheduler assertion macros
// Concurrent assertion shorthands clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HRRN_SCHEDULER_TOP_ASSERT_SVH
`define HRRN_SCHEDULER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HRRN_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define HRRN_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define HRRN_ASSERT_IMP(label, ante, cons, msg)
`define HRRN_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/hrrn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HRRN scheduler package
// Sequencer states, action codes and the divider status group.
// ----------------------------------------------------------------------------
package hrrn_pkg;

   localparam logic ACT_ARRIVAL = 1'b0;
   localparam logic ACT_TICK    = 1'b1;

   typedef enum logic [10:0] {
      S_IDLE    = 11'b00000000001,
      S_ARR_RD  = 11'b00000000010,
      S_ARR_WR  = 11'b00000000100,
      S_ARR_PUT = 11'b00000001000,
      S_SEL_RD  = 11'b00000010000,
      S_SEL_GO  = 11'b00000100000,
      S_SEL_DIV = 11'b00001000000,
      S_SEL_END = 11'b00010000000,
      S_UPD_RD  = 11'b00100000000,
      S_UPD_WR  = 11'b01000000000,
      S_DONE    = 11'b10000000000
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== hw/rtl/hrrn_scheduler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HRRN scheduler top level
// Non-preemptive highest-response-ratio-next scheduler with a waiting table.
// ----------------------------------------------------------------------------
// Usage: an item on the req_ channel is either an arrival (process id and
// burst time go into the lowest free table slot) or a scheduler tick. Each
// item gives exactly one rsp_ item with the running process id, a running
// flag and a flag that is set when an arrival found the table full.
// The table lives in one RAM; a small sequencer sweeps it one slot at a time.
// An arrival sweeps the whole table, then writes the new entry; a full-table
// drop skips the sweep. A tick that selects runs each waiting entry's response
// ratio through the shared bit-serial divider.
// req_ready is high only while the sequencer is idle; one item is in work
// at a time. The result sits in an output register, so the next item may be
// taken while it waits; if rsp_ready stays low, the following item finishes
// its work and then holds until the register frees.
// Reset (synchronous, active high) empties the table and stops the running
// job at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module hrrn_scheduler_top
   import hrrn_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int TIME_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_process_id,
   input  logic [15:0] req_burst_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_running_id,
   output logic        rsp_running_valid,
   output logic        rsp_arrival_dropped
);

`include "hrrn_scheduler_top_assert.svh"

   localparam int AB   = $clog2(QUEUE_DEPTH);
   localparam int TB   = TIME_BITS;
   localparam int EW   = 8 + 2 * TB + AB;
   localparam int ID_H = EW - 1;
   localparam int TM_H = 2 * TB + AB - 1;
   localparam int CT_H = TB + AB - 1;
   localparam logic [AB-1:0] LAST = AB'(QUEUE_DEPTH - 1);
   localparam logic [TB-1:0] TMAX = {TB{1'b1}};

   state_type state_ff, state_in;
   logic [AB-1:0]          idx_ff, idx_in;
   logic [QUEUE_DEPTH-1:0] vld_ff, vld_in;
   logic [AB:0]            cnt_ff, cnt_in;
   logic [7:0]             run_id_ff, run_id_in;
   logic [TB-1:0]          run_time_ff, run_time_in;
   logic                   run_vld_ff, run_vld_in;
   logic [7:0]             pid_ff, pid_in;
   logic [TB-1:0]          burst_ff, burst_in;
   logic [AB-1:0]          free_ff, free_in;
   logic                   free_hit_ff, free_hit_in;
   logic [AB-1:0]          best_slot_ff, best_slot_in;
   logic [7:0]             best_id_ff, best_id_in;
   logic [TB-1:0]          best_time_ff, best_time_in;
   logic [AB-1:0]          best_rank_ff, best_rank_in;
   logic [TB:0]            best_q_ff, best_q_in;
   logic                   best_hit_ff, best_hit_in;
   logic [EW-1:0]          ent_ff, ent_in;
   logic                   drop_ff, drop_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_id_ff, rsp_id_in;
   logic                   rsp_run_ff, rsp_run_in;
   logic                   rsp_drop_ff, rsp_drop_in;

   logic                   ram_wr_en;
   logic [AB-1:0]          ram_wr_addr;
   logic [EW-1:0]          ram_wr_data;
   logic [EW-1:0]          ram_rd_data;

   logic                   div_start;
   logic [TB:0]            div_dividend;
   logic [TB-1:0]          div_divisor;
   logic [TB:0]            div_quo;
   div_stat_type           div_stat;

   logic [TB-1:0]          rd_time;
   logic [TB-1:0]          rd_count;
   logic [AB-1:0]          rd_rank;
   logic [AB-1:0]          ent_rank;
   logic                   idx_last;

   assign rd_time  = ram_rd_data[TM_H -: TB];
   assign rd_count = ram_rd_data[CT_H -: TB];
   assign rd_rank  = ram_rd_data[AB-1:0];
   assign ent_rank = ent_ff[AB-1:0];
   assign idx_last = idx_ff == LAST;

   // A zero burst time divides by one.
   assign div_dividend = {1'b0, rd_count} + {1'b0, rd_time};
   assign div_divisor  = (rd_time == '0) ? TB'(1) : rd_time;

   hrrn_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   hrrn_div #(
      .TIME_BITS (TB)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      vld_in       = vld_ff;
      cnt_in       = cnt_ff;
      run_id_in    = run_id_ff;
      run_time_in  = run_time_ff;
      run_vld_in   = run_vld_ff;
      pid_in       = pid_ff;
      burst_in     = burst_ff;
      free_in      = free_ff;
      free_hit_in  = free_hit_ff;
      best_slot_in = best_slot_ff;
      best_id_in   = best_id_ff;
      best_time_in = best_time_ff;
      best_rank_in = best_rank_ff;
      best_q_in    = best_q_ff;
      best_hit_in  = best_hit_ff;
      ent_in       = ent_ff;
      drop_in      = drop_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_run_in   = rsp_run_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = idx_ff;
      ram_wr_data  = ram_rd_data;
      div_start    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pid_in   = req_process_id;
               burst_in = TB'(req_burst_time);
               drop_in  = 1'b0;
               idx_in   = '0;
               if (req_action == ACT_ARRIVAL) begin
                  if (cnt_ff == (AB + 1)'(QUEUE_DEPTH)) begin
                     drop_in  = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     free_hit_in = 1'b0;
                     state_in    = S_ARR_RD;
                  end
               end else begin
                  best_hit_in = 1'b0;
                  if (!run_vld_ff || run_time_ff == '0) begin
                     state_in = S_SEL_RD;
                  end else begin
                     run_time_in = run_time_ff - 1'b1;
                     state_in    = S_UPD_RD;
                  end
               end
            end
         end
         S_ARR_RD: begin
            state_in = S_ARR_WR;
         end
         S_ARR_WR: begin
            // Every waiting entry ages by one rank; the first free slot is kept.
            if (vld_ff[idx_ff]) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = {ram_rd_data[EW-1:AB], rd_rank + 1'b1};
            end else if (!free_hit_ff) begin
               free_hit_in = 1'b1;
               free_in     = idx_ff;
            end
            if (idx_last) begin
               state_in = S_ARR_PUT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_ARR_RD;
            end
         end
         S_ARR_PUT: begin
            ram_wr_en       = 1'b1;
            ram_wr_addr     = free_ff;
            ram_wr_data     = {pid_ff, burst_ff, {TB{1'b0}}, {AB{1'b0}}};
            vld_in[free_ff] = 1'b1;
            cnt_in          = cnt_ff + 1'b1;
            state_in        = S_DONE;
         end
         S_SEL_RD: begin
            if (vld_ff[idx_ff]) begin
               state_in = S_SEL_GO;
            end else if (idx_last) begin
               state_in = S_SEL_END;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_SEL_GO: begin
            ent_in    = ram_rd_data;
            div_start = 1'b1;
            state_in  = S_SEL_DIV;
         end
         S_SEL_DIV: begin
            if (div_stat.done) begin
               // Equal ratios go to the lower rank, the more recent arrival.
               if (!best_hit_ff || div_quo > best_q_ff ||
                   (div_quo == best_q_ff && ent_rank < best_rank_ff)) begin
                  best_hit_in  = 1'b1;
                  best_q_in    = div_quo;
                  best_slot_in = idx_ff;
                  best_id_in   = ent_ff[ID_H -: 8];
                  best_time_in = ent_ff[TM_H -: TB];
                  best_rank_in = ent_rank;
               end
               if (idx_last) begin
                  state_in = S_SEL_END;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_SEL_RD;
               end
            end
         end
         S_SEL_END: begin
            idx_in = '0;
            if (best_hit_ff) begin
               run_vld_in           = 1'b1;
               run_id_in            = best_id_ff;
               run_time_in          = (best_time_ff == '0) ? '0 : best_time_ff - 1'b1;
               vld_in[best_slot_ff] = 1'b0;
               cnt_in               = cnt_ff - 1'b1;
               state_in             = S_UPD_RD;
            end else begin
               run_vld_in  = 1'b0;
               run_id_in   = '0;
               run_time_in = '0;
               state_in    = S_DONE;
            end
         end
         S_UPD_RD: begin
            if (vld_ff[idx_ff]) begin
               state_in = S_UPD_WR;
            end else if (idx_last) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_UPD_WR: begin
            // Entries older than the one just removed move up one rank.
            ram_wr_en   = 1'b1;
            ram_wr_data = {ram_rd_data[ID_H -: 8], rd_time,
                           (rd_count == TMAX) ? rd_count : rd_count + 1'b1,
                           (best_hit_ff && rd_rank > best_rank_ff) ? rd_rank - 1'b1
                                                                  : rd_rank};
            if (idx_last) begin
               state_in = S_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_UPD_RD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = run_vld_ff ? run_id_ff : 8'd0;
               rsp_run_in   = run_vld_ff;
               rsp_drop_in  = drop_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         vld_ff       <= '0;
         cnt_ff       <= '0;
         run_id_ff    <= '0;
         run_time_ff  <= '0;
         run_vld_ff   <= 1'b0;
         free_hit_ff  <= 1'b0;
         best_hit_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         vld_ff       <= vld_in;
         cnt_ff       <= cnt_in;
         run_id_ff    <= run_id_in;
         run_time_ff  <= run_time_in;
         run_vld_ff   <= run_vld_in;
         free_hit_ff  <= free_hit_in;
         best_hit_ff  <= best_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pid_ff       <= pid_in;
      burst_ff     <= burst_in;
      free_ff      <= free_in;
      best_slot_ff <= best_slot_in;
      best_id_ff   <= best_id_in;
      best_time_ff <= best_time_in;
      best_rank_ff <= best_rank_in;
      best_q_ff    <= best_q_in;
      ent_ff       <= ent_in;
      drop_ff      <= drop_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_run_ff   <= rsp_run_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   assign req_ready           = state_ff == S_IDLE;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_running_id      = rsp_id_ff;
   assign rsp_running_valid   = rsp_run_ff;
   assign rsp_arrival_dropped = rsp_drop_ff;

   `HRRN_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready,
                    "item accepted but sequencer still ready")
   `HRRN_ASSERT_IMP(a_fill_count, 1'b1, cnt_ff == $countones(vld_ff),
                    "fill count disagrees with valid bits")
   `HRRN_ASSERT_IMP(a_idle_id_zero, rsp_valid && !rsp_running_valid,
                    rsp_running_id == 8'd0, "idle result carries a nonzero id")
   `HRRN_ASSERT_IMP(a_div_in_select, div_stat.busy, state_ff == S_SEL_DIV,
                    "divider busy outside ratio step")

endmodule

// ===== hw/rtl/hrrn_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HRRN generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hrrn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/hrrn_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HRRN ratio divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hrrn_div
   import hrrn_pkg::*;
#(
   parameter int TIME_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [TIME_BITS:0]   dividend,
   input  logic [TIME_BITS-1:0] divisor,
   output logic [TIME_BITS:0]   quotient,
   output div_stat_type         stat
);

   localparam int CW = $clog2(TIME_BITS + 2);

   logic [TIME_BITS-1:0] rem_ff, rem_in;
   logic [TIME_BITS:0]   quo_ff, quo_in;
   logic [TIME_BITS-1:0] dsr_ff, dsr_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [TIME_BITS:0]   trial;
   logic                 fits;

   // The dividend shifts out of the top of quo_ff while quotient bits enter below.
   assign trial = {rem_ff, quo_ff[TIME_BITS]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = CW'(TIME_BITS + 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? TIME_BITS'(trial - {1'b0, dsr_ff}) : TIME_BITS'(trial);
         quo_in = {quo_ff[TIME_BITS-1:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== test/hrrn_scheduler_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HRRN scheduler top level testbench
// Drives arrivals and ticks with random gaps and response stalls. A scoreboard
// class keeps its own copy of the waiting table and the running job, predicts
// each response, and checks every response in order against that prediction.
// ----------------------------------------------------------------------------
module hrrn_scheduler_top_tb
   import hrrn_pkg::*;
();

   localparam int DEPTH      = 16;
   localparam int TBITS      = 16;
   localparam int N_RANDOM   = 1900;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic [7:0] running_id;
      logic       running_valid;
      logic       arrival_dropped;
   } sched_result_type;

   class sched_scoreboard;
      logic [7:0]       tbl_id[DEPTH];
      logic [TBITS-1:0] tbl_left[DEPTH];
      logic [TBITS-1:0] tbl_wait[DEPTH];
      logic [15:0]      tbl_age[DEPTH];
      bit               tbl_used[DEPTH];
      logic [7:0]       cur_id;
      logic [TBITS-1:0] cur_left;
      bit               cur_run;
      sched_result_type pending[$];
      int               errors;
      int               checked;
      int               drops;
      int               selections;

      function new();
         for (int i = 0; i < DEPTH; i++) begin
            tbl_used[i] = 0;
         end
         cur_id = 0;
         cur_left = 0;
         cur_run = 0;
         errors = 0;
         checked = 0;
         drops = 0;
         selections = 0;
      endfunction

      function int occupancy();
         int n;
         n = 0;
         for (int i = 0; i < DEPTH; i++) begin
            n += tbl_used[i];
         end
         return n;
      endfunction

      function void pick_next();
         int          best;
         logic [32:0] r;
         logic [32:0] best_r;
         best = -1;
         best_r = 0;
         for (int i = 0; i < DEPTH; i++) begin
            if (tbl_used[i]) begin
               r = ({17'd0, tbl_wait[i]} + tbl_left[i]) /
                   ((tbl_left[i] == 0) ? 33'd1 : {17'd0, tbl_left[i]});
               if (best < 0 || r > best_r || (r == best_r && tbl_age[i] < tbl_age[best]))
               begin
                  best = i;
                  best_r = r;
               end
            end
         end
         if (best < 0) begin
            cur_run = 0;
            cur_id = 0;
            cur_left = 0;
         end else begin
            selections++;
            cur_run = 1;
            cur_id = tbl_id[best];
            cur_left = tbl_left[best];
            tbl_used[best] = 0;
            for (int i = 0; i < DEPTH; i++) begin
               if (tbl_used[i] && tbl_age[i] > tbl_age[best]) tbl_age[i]--;
            end
         end
      endfunction

      // Notes one accepted item and queues the response it must cause.
      function void note_item(logic action, logic [7:0] pid, logic [15:0] burst);
         int               slot;
         sched_result_type res;
         res.arrival_dropped = 0;
         if (action == ACT_ARRIVAL) begin
            slot = -1;
            for (int i = DEPTH - 1; i >= 0; i--) begin
               if (!tbl_used[i]) slot = i;
            end
            if (slot < 0) begin
               res.arrival_dropped = 1;
               drops++;
            end else begin
               for (int i = 0; i < DEPTH; i++) begin
                  if (tbl_used[i]) tbl_age[i]++;
               end
               tbl_id[slot] = pid;
               tbl_left[slot] = burst[TBITS-1:0];
               tbl_wait[slot] = 0;
               tbl_age[slot] = 0;
               tbl_used[slot] = 1;
            end
         end else begin
            if (!cur_run || cur_left == 0) pick_next();
            if (cur_run) begin
               if (cur_left != 0) cur_left--;
               for (int i = 0; i < DEPTH; i++) begin
                  if (tbl_used[i] && tbl_wait[i] != '1) tbl_wait[i]++;
               end
            end
         end
         res.running_id = cur_run ? cur_id : 8'd0;
         res.running_valid = cur_run;
         pending.push_back(res);
      endfunction

      function void check_result(sched_result_type got);
         sched_result_type want;
         checked++;
         if (pending.size() == 0) begin
            report_mismatch("response with nothing expected", 0, 0);
            return;
         end
         want = pending.pop_front();
         if (got.running_id !== want.running_id)
            report_mismatch("running_id", got.running_id, want.running_id);
         if (got.running_valid !== want.running_valid)
            report_mismatch("running_valid", got.running_valid, want.running_valid);
         if (got.arrival_dropped !== want.arrival_dropped)
            report_mismatch("arrival_dropped", got.arrival_dropped, want.arrival_dropped);
      endfunction

      function void report_mismatch(string what, int got, int want);
         errors++;
         $display("MISMATCH at %0t, response %0d: %s got %0d expected %0d",
                  $realtime, checked, what, got, want);
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_action = ACT_TICK;
   logic [7:0]  req_process_id = 0;
   logic [15:0] req_burst_time = 1;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [7:0]  rsp_running_id;
   logic        rsp_running_valid;
   logic        rsp_arrival_dropped;

   sched_scoreboard board = new();
   bit  calm = 0;       // no idling on either side
   bit  hold_off = 0;   // long response stall requested
   int  quiet_cycles = 0;

   hrrn_scheduler_top i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_action, .req_process_id,
      .req_burst_time, .rsp_valid, .rsp_ready, .rsp_running_id,
      .rsp_running_valid, .rsp_arrival_dropped
   );

   always #5 clock = ~clock;

   // Response side: check on accept, then choose ready for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result({rsp_running_id, rsp_running_valid, rsp_arrival_dropped});
      if (reset || hold_off) begin
         rsp_ready <= 0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 12);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles > IDLE_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
         $display("hrrn_scheduler_top regression: fail");
         $finish;
      end
   end

   // Offers one item and returns after it is accepted. Valid stays high into
   // the next item unless this side idles first.
   task automatic send_item(logic action, logic [7:0] pid, logic [15:0] burst);
      if (!calm && $urandom_range(99) < 12) begin
         req_valid <= 0;
         do begin
            @(posedge clock);
         end while ($urandom_range(99) < 12);
      end
      req_valid <= 1;
      req_action <= action;
      req_process_id <= pid;
      req_burst_time <= burst;
      do begin
         @(posedge clock);
      end while (!req_ready);
      board.note_item(action, pid, burst);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
   endtask

   // Short bursts keep jobs finishing; ticks outnumber arrivals a little.
   task automatic random_item();
      logic [15:0] burst;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 70) burst = 16'($urandom_range(4, 1));
      else if (pick < 90) burst = 16'($urandom_range(40, 1));
      else if (pick < 95) burst = 16'($urandom_range(65535, 1));
      else burst = 0;
      if (board.occupancy() >= DEPTH - 1 && $urandom_range(3) != 0) begin
         send_item(ACT_TICK, 0, 1);
      end else begin
         send_item($urandom_range(99) < 55 ? ACT_TICK : ACT_ARRIVAL,
                   8'($urandom_range(255)), burst);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: ticks on an empty table, then field extremes.
      send_item(ACT_TICK, 0, 1);
      send_item(ACT_TICK, 8'hFF, 16'hFFFF);
      send_item(ACT_ARRIVAL, 8'hFF, 16'hFFFF);
      send_item(ACT_ARRIVAL, 8'h00, 16'h0001);
      send_item(ACT_ARRIVAL, 8'hA5, 16'h0000);
      send_item(ACT_ARRIVAL, 8'h5A, 16'h0001);
      // Ratio tie among three waiting jobs goes to the newest arrival.
      for (int i = 0; i < 6; i++) send_item(ACT_TICK, 0, 1);
      // Fill the table and overflow it.
      for (int i = 0; i < DEPTH + 2; i++) send_item(ACT_ARRIVAL, 8'(8'h10 + i), 16'h0002);
      drain();

      // Long response stall while the sender keeps offering items.
      hold_off = 1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         for (int i = 0; i < 10; i++) random_item();
      join
      drain();

      calm = 1;
      for (int i = 0; i < 200; i++) random_item();
      calm = 0;
      for (int i = 0; i < N_RANDOM - 200; i++) random_item();

      drain();
      $display("covered %0d responses, %0d selections, %0d dropped arrivals",
               board.checked, board.selections, board.drops);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("hrrn_scheduler_top regression: pass");
      end else begin
         $display("hrrn_scheduler_top regression: fail");
      end
      $finish;
   end
endmodule
